// ===== rtl/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned RunLenW   = 11;
  localparam int unsigned MaxLenDef = 1024;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [RunLenW-1:0]       run_len_t;

  // Search request handed to the sequencer.
  typedef struct packed {
    value_t value;
    logic   start_req;
  } lis_req_t;

  // Result returned by the sequencer.
  typedef struct packed {
    run_len_t run_length;
    logic     full_res;
  } lis_rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StProbe,
    StUpdate,
    StResp
  } lis_state_e;

endpackage

// ===== rtl/lis_in_if.sv =====
// ----------------------------------------------------------------------------
// lis_in_if
// Input channel: one sequence element per transaction.
// ----------------------------------------------------------------------------
interface lis_in_if;
  import lis_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   start_req;

  modport source (output valid, output value, output start_req, input ready);
  modport sink   (input valid, input value, input start_req, output ready);

endinterface

// ===== rtl/lis_out_if.sv =====
// ----------------------------------------------------------------------------
// lis_out_if
// Output channel: running length and full flag, one transaction per element.
// ----------------------------------------------------------------------------
interface lis_out_if;
  import lis_pkg::*;

  logic     valid;
  logic     ready;
  run_len_t run_length;
  logic     full_res;

  modport source (output valid, output run_length, output full_res, input ready);
  modport sink   (input valid, input run_length, input full_res, output ready);

endinterface

// ===== rtl/lis_ram.sv =====
// ----------------------------------------------------------------------------
// lis_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lis_seq.sv =====
// ----------------------------------------------------------------------------
// lis_seq
// Binary search sequencer: one tail compare per cycle, then one tail update.
// ----------------------------------------------------------------------------
module lis_seq #(
  parameter int unsigned MAX_LEN = lis_pkg::MaxLenDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  lis_pkg::lis_req_t          req_i,
  output logic                       req_ready_o,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output lis_pkg::lis_rsp_t          rsp_o,
  output logic                       ram_we_o,
  output logic [$clog2(MAX_LEN)-1:0] ram_waddr_o,
  output logic [lis_pkg::ValueW-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [$clog2(MAX_LEN)-1:0] ram_raddr_o,
  input  logic [lis_pkg::ValueW-1:0] ram_rdata_i
);
  import lis_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AddrW = $clog2(MAX_LEN);

  lis_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW-1:0] mid_q, mid_d;
  value_t          key_q, key_d;
  logic            full_q, full_d;

  logic            tail_ge;
  logic [CntW-1:0] lo_n, hi_n, mid_n, span_n, hi_init;

  // The one shared comparator: the tail just read against the key.
  assign tail_ge = $signed(ram_rdata_i) >= key_q;
  assign lo_n    = tail_ge ? lo_q : mid_q + CntW'(1);
  assign hi_n    = tail_ge ? mid_q : hi_q;
  assign span_n  = hi_n - lo_n;
  assign mid_n   = lo_n + (span_n >> 1);
  assign hi_init = req_i.start_req ? '0 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    full_d      = full_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = mid_q[AddrW-1:0];
    ram_we_o    = 1'b0;
    ram_waddr_o = lo_q[AddrW-1:0];
    ram_wdata_o = key_q;

    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          key_d = req_i.value;
          lo_d  = '0;
          hi_d  = hi_init;
          mid_d = hi_init >> 1;
          if (req_i.start_req) begin
            cnt_d = '0;
          end
          if (hi_init != '0) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = mid_d[AddrW-1:0];
            state_d     = StProbe;
          end else begin
            state_d = StUpdate;
          end
        end
      end
      StProbe: begin
        lo_d = lo_n;
        hi_d = hi_n;
        // Issue the next probe in the same cycle the range narrows.
        if (lo_n < hi_n) begin
          mid_d       = mid_n;
          ram_re_o    = 1'b1;
          ram_raddr_o = mid_n[AddrW-1:0];
        end else begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        full_d = 1'b0;
        if (lo_q < cnt_q) begin
          ram_we_o = 1'b1;
        end else if (cnt_q < CntW'(MAX_LEN)) begin
          ram_we_o = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end else begin
          full_d = 1'b1;
        end
        state_d = StResp;
      end
      StResp: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign rsp_o.run_length = RunLenW'(cnt_q);
  assign rsp_o.full_res   = full_q;

endmodule

// ===== rtl/longest_increasing_subsequence_length.sv =====
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length
// Patience-sorting tracker of the longest strictly increasing subsequence.
// Each element takes P tail probes (0 for an empty store, at most
// clog2(count + 1), 11 at 1024), then a tail update and a response.
// One element is handled at a time; the binary search runs over the single
// read port of the tail RAM, one probe per cycle.
// Reset clears the tail count and output valid; tail RAM contents are left.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length #(
  parameter int unsigned MAX_LEN = lis_pkg::MaxLenDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source out_o
);
  import lis_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_LEN);

  lis_req_t         req;
  lis_rsp_t         rsp;
  logic             rsp_valid, rsp_ready;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;

  logic     out_valid_q;
  run_len_t out_len_q;
  logic     out_full_q;

  assign req.value     = in_i.value;
  assign req.start_req = in_i.start_req;

  lis_seq #(.MAX_LEN(MAX_LEN)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_i       (req),
    .req_ready_o (in_i.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lis_ram #(.Width(ValueW), .Depth(MAX_LEN)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register lets the sequencer take a new element while a
  // finished result still waits for the sink.
  assign rsp_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_len_q  <= rsp.run_length;
      out_full_q <= rsp.full_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.run_length = out_len_q;
  assign out_o.full_res   = out_full_q;

endmodule

// ===== rtl/lis_checker.sv =====
// ----------------------------------------------------------------------------
// lis_checker
// Port-level checks for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
module lis_checker #(
  parameter int unsigned MAX_LEN = lis_pkg::MaxLenDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [lis_pkg::RunLenW-1:0] run_length_i,
  input logic                        full_res_i
);
  import lis_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(run_length_i)
      && $stable(full_res_i))
    else $error("stalled result changed");

  // The block works on one element at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("element accepted while search busy");

  // A dropped append only happens with a saturated length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && full_res_i |-> run_length_i == RunLenW'(MAX_LEN))
    else $error("full flag without saturated length");

  // The length never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (MAX_LEN > 2047) || (run_length_i <= RunLenW'(MAX_LEN)))
    else $error("length beyond store depth");

endmodule

bind longest_increasing_subsequence_length lis_checker #(.MAX_LEN(MAX_LEN)) u_lis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .run_length_i (out_o.run_length),
  .full_res_i   (out_o.full_res)
);

// ===== tb/longest_increasing_subsequence_length_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length_tb
// Drives signed elements into the subsequence tracker and checks every running
// length and store-full flag against a patience-sorting predictor kept in the
// bench. Covers value extremes, equal values, restarts, a run that fills the
// tail store, random sequences, random idling on both channels, a long sink
// stall and a source pause that waits for all results to drain.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length_tb;
  import lis_pkg::*;

  localparam int unsigned TailDepth     = MaxLenDef;
  localparam int unsigned IdlePct       = 25;
  localparam int unsigned CalmFrom      = 4000;
  localparam int unsigned CalmTo        = 9000;
  localparam int unsigned HoldoffAt     = 200;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned RandomElems   = 200;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned MaxPrinted    = 20;
  localparam value_t      MinVal        = 32'sh8000_0000;
  localparam value_t      MaxVal        = 32'sh7FFF_FFFF;

  typedef enum int unsigned {
    ShapeWide,
    ShapeNarrow,
    ShapeRising,
    ShapeFalling
  } seq_shape_e;

  typedef struct {
    lis_req_t req;
    bit       drain_first;
  } pending_elem_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lis_in_if  in_if ();
  lis_out_if out_if ();

  longest_increasing_subsequence_length dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  pending_elem_t pending_elems[$];
  lis_rsp_t      expected_lengths[$];

  // Predicted tail store and its fill count.
  value_t      tail_model[TailDepth];
  int unsigned tail_model_count = 0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned elems_queued   = 0;
  int unsigned elems_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned full_results   = 0;
  int unsigned longest_seen   = 0;
  int unsigned sequences      = 0;
  int unsigned holdoff_left;
  int unsigned holdoff_seen;
  bit          holdoff_armed;
  logic        calm;

  assign calm = (cycle_count >= CalmFrom) && (cycle_count < CalmTo);

  // Patience step: replace the first tail not below the element, else append while the store has room.
  function automatic lis_rsp_t advance_tails(value_t elem, logic restart);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lis_rsp_t    rsp;
    if (restart) tail_model_count = 0;
    lo = 0;
    hi = tail_model_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (tail_model[mid] >= elem) hi = mid;
      else lo = mid + 1;
    end
    rsp.full_res = 1'b0;
    if (lo < tail_model_count) begin
      tail_model[lo] = elem;
    end else if (tail_model_count < TailDepth) begin
      tail_model[tail_model_count] = elem;
      tail_model_count++;
    end else begin
      rsp.full_res = 1'b1;
    end
    rsp.run_length = run_len_t'(tail_model_count);
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    if (mismatch_count < MaxPrinted) begin
      $display("[%0t] result %0d: %s expected %0d, got %0d",
               $realtime, results_seen, what, want, got);
    end
    mismatch_count++;
  endtask

  task automatic add_elem(value_t v, logic restart, bit drain_first = 1'b0);
    pending_elem_t item;
    item.req.value     = v;
    item.req.start_req = restart;
    item.drain_first   = drain_first;
    pending_elems.insert(pending_elems.size(), item);
    elems_queued++;
    if (restart) sequences++;
  endtask

  // One sequence of random content; a stray restart now and then acts as noise.
  task automatic add_sequence(int unsigned n, seq_shape_e shape, bit restart);
    value_t      v;
    int          step;
    int unsigned k;
    v = $urandom;
    for (k = 0; k < n; k++) begin
      step = int'($urandom_range(0, 1000)) - 100;
      case (shape)
        ShapeWide:    v = $urandom;
        ShapeNarrow:  v = int'($urandom_range(0, 16)) - 8;
        ShapeRising:  v = v + step;
        ShapeFalling: v = v - step;
        default:      v = $urandom;
      endcase
      add_elem(v, (k == 0 && restart) || ($urandom_range(0, 49) == 0));
    end
  endtask

  task automatic add_random_part(int unsigned count);
    int unsigned target;
    int unsigned n;
    target = elems_queued + count;
    while (elems_queued < target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
      add_sequence(n, seq_shape_e'($urandom_range(0, 3)), $urandom_range(0, 9) != 0);
    end
  endtask

  // Strictly increasing run that overflows the store, then a repeat of its last
  // value that overflows again, one replacement and one more overflowing append.
  task automatic add_full_run();
    value_t      v;
    int unsigned k;
    v = MinVal;
    add_elem(v, 1'b1, 1'b1);
    for (k = 1; k < TailDepth + 6; k++) begin
      v = v + value_t'($urandom_range(1, 2000000));
      add_elem(v, 1'b0);
    end
    add_elem(v, 1'b0);
    add_elem(MinVal, 1'b0);
    add_elem(MaxVal, 1'b0);
  endtask

  // Source side: holds an offered transaction until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : elem_driver
    bit offer;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.value     <= '0;
      in_if.start_req <= 1'b0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_lengths.insert(expected_lengths.size(),
                                advance_tails(in_if.value, in_if.start_req));
        void'(pending_elems.pop_front());
        elems_accepted++;
        offer = 1'b0;
      end
      if (!offer && pending_elems.size() != 0) begin
        offer = !(pending_elems[0].drain_first && expected_lengths.size() != 0) &&
                (holdoff_left != 0 || calm || $urandom_range(0, 99) >= IdlePct);
      end
      in_if.valid <= offer;
      if (offer) begin
        in_if.value     <= pending_elems[0].req.value;
        in_if.start_req <= pending_elems[0].req.start_req;
      end
    end
  end

  // Long sink stall once enough transactions have gone in.
  always @(posedge clk_i or negedge rst_ni) begin : sink_holdoff
    if (!rst_ni) begin
      holdoff_left  <= 0;
      holdoff_seen  <= 0;
      holdoff_armed <= 1'b1;
    end else begin
      if (in_if.valid && in_if.ready) holdoff_seen <= holdoff_seen + 1;
      if (holdoff_armed && holdoff_seen == HoldoffAt) begin
        holdoff_left  <= HoldoffCycles;
        holdoff_armed <= 1'b0;
      end else if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : length_monitor
    lis_rsp_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_lengths.size() == 0) begin
          report_mismatch("unexpected result, run_length", 0, out_if.run_length);
        end else begin
          want = expected_lengths.pop_front();
          if (out_if.run_length !== want.run_length) begin
            report_mismatch("run_length", want.run_length, out_if.run_length);
          end
          if (out_if.full_res !== want.full_res) begin
            report_mismatch("full_res", want.full_res, out_if.full_res);
          end
          if (want.full_res) full_results++;
          if (want.run_length > longest_seen) longest_seen = want.run_length;
        end
        results_seen++;
      end
      out_if.ready <= (holdoff_left == 0) && (calm || $urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("longest_increasing_subsequence_length_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;

    // Fresh store after reset, extremes, equal values and alternating bits.
    add_elem(32'sd0, 1'b0);
    add_elem(MinVal, 1'b1);
    add_elem(MaxVal, 1'b0);
    add_elem(MaxVal, 1'b0);
    add_elem(MinVal, 1'b0);
    add_elem(32'sd0, 1'b0);
    add_elem(32'sd1, 1'b0);
    add_elem(-32'sd1, 1'b0);
    add_elem(32'shAAAA_AAAA, 1'b0);
    add_elem(32'sh5555_5555, 1'b0);
    add_elem(MaxVal, 1'b1);
    add_elem(MinVal, 1'b0);
    add_elem(MinVal, 1'b0);
    add_elem(32'sd5, 1'b1);
    add_elem(32'sd4, 1'b0);
    add_elem(32'sd3, 1'b0);
    add_elem(32'sd2, 1'b0);
    add_elem(32'sd1, 1'b0);
    add_elem(32'sd2, 1'b0);
    add_elem(32'sd3, 1'b0);
    add_elem(32'sd3, 1'b0);
    add_elem(MaxVal, 1'b0);

    add_elem($urandom, 1'b1, 1'b1);
    add_random_part(RandomElems);
    add_full_run();
    add_elem($urandom, 1'b1, 1'b1);
    add_random_part(RandomElems);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_elems.size() != 0 || expected_lengths.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (expected_lengths.size() != 0) begin
      report_mismatch("results never returned, count", 0, expected_lengths.size());
    end
    $display("Checked %0d results for %0d elements over %0d restarted sequences.",
             results_seen, elems_accepted, sequences);
    $display("Longest run %0d, %0d store-full results, %0d mismatches.",
             longest_seen, full_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("longest_increasing_subsequence_length_tb passed");
    end else begin
      $display("longest_increasing_subsequence_length_tb failed");
    end
    $finish;
  end

endmodule
